FILE: sv/bounded_stack_with_reverse_macros.svh
// Assertion macros for the bounded stack checker.
// Used by bsr_checker; expects clk and rst_n in the scope of each use.
`ifndef BOUNDED_STACK_WITH_REVERSE_MACROS_SVH
`define BOUNDED_STACK_WITH_REVERSE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define BSR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define BSR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/bsr_pkg.sv
// Shared types, constants and helpers for the bounded stack.
// No dependencies; used by every file of the block except bsr_ram and the macros.
package bsr_pkg;

    // Storage geometry
    localparam int DEPTH   = 1024;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);

    // Field widths fixed by the interface
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 11;
    localparam int CAP_W   = 11;
    localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    // Configuration
    localparam int         PADDR_W      = 3;
    localparam logic       REG_CAPACITY = 1'b0;
    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REV  = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;

    // RAM request from the sequencer
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

    // Operands for the shared add/subtract unit
    typedef struct packed {
        logic [CNT_W-1:0] a;
        logic [CNT_W-1:0] b;
        logic             sub;
    } au_req_t;

    // Fill level as reported on the result, masked to the field width
    function automatic logic [COUNT_W-1:0] to_count(input logic [CNT_W-1:0] fill);
        logic [CMP_W-1:0] ext;
        ext = CMP_W'(fill);
        return ext[COUNT_W-1:0];
    endfunction

endpackage

FILE: sv/bsr_in_if.sv
// Command channel of the bounded stack: valid/ready plus command payload.
// Depends on bsr_pkg for field widths.
interface bsr_in_if;
    logic                                valid;
    logic                                ready;
    logic [bsr_pkg::CMD_W-1:0]           cmd;
    logic signed [bsr_pkg::DATA_W-1:0]   push_value;

    modport source (output valid, output cmd, output push_value, input ready);
    modport sink   (input valid, input cmd, input push_value, output ready);
endinterface

FILE: sv/bsr_out_if.sv
// Result channel of the bounded stack: valid/ready plus result payload.
// Depends on bsr_pkg for field widths.
interface bsr_out_if;
    logic                                valid;
    logic                                ready;
    logic [bsr_pkg::STAT_W-1:0]          status;
    logic signed [bsr_pkg::DATA_W-1:0]   pop_value;
    logic [bsr_pkg::COUNT_W-1:0]         entry_count;

    modport source (output valid, output status, output pop_value, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input pop_value, input entry_count,
                    output ready);
endinterface

FILE: sv/bounded_stack_with_reverse.sv
// Bounded LIFO stack of signed 32-bit words, 1024 entries, one command at a time.
// A push or pop makes one RAM access and then loads the result register. A
// reverse of fewer than two entries goes straight to the result register. A
// reverse of two or more entries runs a swap loop that reads both ends and
// writes both ends through the single write port of the stack RAM. The
// command channel is not ready while a command is in progress, but a new
// command is taken while the previous result still waits. Overflow and
// underflow leave the stack unchanged. capacity (APB byte address 0, reset
// 1024) must be written only while the block is idle; the block does not enforce it.
// Depends on bsr_pkg, bsr_in_if, bsr_out_if, bsr_ram, bsr_addsub and bsr_seq.
module bounded_stack_with_reverse (
    input  logic                          clk,
    input  logic                          rst_n,
    bsr_in_if.sink                        cmd_ch,
    bsr_out_if.source                     res_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bsr_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import bsr_pkg::*;

    logic [CAP_W-1:0]  cap_reg, cap_next;
    ram_req_t          ram_req;
    logic [DATA_W-1:0] rdata;
    au_req_t           au_req;
    logic [CNT_W:0]    au_res;
    logic              cfg_sel;

    // Configuration register
    assign pready  = 1'b1;
    assign cfg_sel = (paddr[2] == REG_CAPACITY);

    always_comb
    begin
        cap_next = cap_reg;
        if (psel && penable && pwrite && pready && cfg_sel)
        begin
            cap_next = pwdata[CAP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else
        begin
            cap_reg <= cap_next;
        end
    end

    assign prdata = cfg_sel ? 32'(cap_reg) : '0;

    // Stack storage
    bsr_ram #(
        .WIDTH (DATA_W),
        .WORDS (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (rdata)
    );

    // Shared arithmetic
    bsr_addsub u_au (
        .req (au_req),
        .res (au_res)
    );

    // Sequencer
    bsr_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_ch   (cmd_ch),
        .res_ch   (res_ch),
        .capacity (cap_reg),
        .ram_req  (ram_req),
        .rdata    (rdata),
        .au_req   (au_req),
        .au_res   (au_res)
    );

endmodule

FILE: sv/bsr_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bsr_ram #(
    parameter int WIDTH = 32,
    parameter int WORDS = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(WORDS)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(WORDS)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [WORDS];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data held while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: sv/bsr_addsub.sv
// Shared add/subtract unit for fill-level and swap-index arithmetic.
// Depends on bsr_pkg; result is one bit wider so a difference keeps its sign.
module bsr_addsub (
    input  bsr_pkg::au_req_t          req,
    output logic [bsr_pkg::CNT_W:0]   res
);
    import bsr_pkg::*;

    always_comb
    begin
        if (req.sub)
        begin
            res = {1'b0, req.a} - {1'b0, req.b};
        end
        else
        begin
            res = {1'b0, req.a} + {1'b0, req.b};
        end
    end

endmodule

FILE: sv/bsr_seq.sv
// Command sequencer of the bounded stack: fill level, swap loop, result register.
// Depends on bsr_pkg and the channel interfaces; drives the RAM and the add/sub unit.
module bsr_seq (
    input  logic                        clk,
    input  logic                        rst_n,
    bsr_in_if.sink                      cmd_ch,
    bsr_out_if.source                   res_ch,
    input  logic [bsr_pkg::CAP_W-1:0]   capacity,
    output bsr_pkg::ram_req_t           ram_req,
    input  logic [bsr_pkg::DATA_W-1:0]  rdata,
    output bsr_pkg::au_req_t            au_req,
    input  logic [bsr_pkg::CNT_W:0]     au_res
);
    import bsr_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD_LO = 3'd1;
    localparam logic [2:0] S_RD_HI = 3'd2;
    localparam logic [2:0] S_WR_LO = 3'd3;
    localparam logic [2:0] S_WR_HI = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [ADDR_W-1:0]  lo_reg, lo_next;
    logic [ADDR_W-1:0]  hi_reg, hi_next;
    logic [DATA_W-1:0]  tmp_reg, tmp_next;
    logic [STAT_W-1:0]  status_reg, status_next;
    logic               pop_ok_reg, pop_ok_next;
    logic               res_valid_reg, res_valid_next;
    logic [STAT_W-1:0]  res_status_reg, res_status_next;
    logic [DATA_W-1:0]  res_pop_reg, res_pop_next;
    logic [COUNT_W-1:0] res_count_reg, res_count_next;

    logic cmd_xfer;
    logic full;
    logic load_res;

    assign cmd_ch.ready = (state_reg == S_IDLE);
    assign cmd_xfer     = cmd_ch.valid && cmd_ch.ready;

    // Full when at or above the configured capacity or at the storage depth
    assign full = (CMP_W'(fill_reg) >= CMP_W'(capacity)) || (fill_reg == CNT_W'(DEPTH));

    assign load_res = (state_reg == S_DONE) && (!res_valid_reg || res_ch.ready);

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        tmp_next      = tmp_reg;
        status_next   = status_reg;
        pop_ok_next   = pop_ok_reg;
        ram_req.we    = 1'b0;
        ram_req.waddr = lo_reg;
        ram_req.wdata = rdata;
        ram_req.re    = 1'b0;
        ram_req.raddr = lo_reg;
        au_req.a      = fill_reg;
        au_req.b      = CNT_W'(1);
        au_req.sub    = (cmd_ch.cmd != CMD_PUSH);

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_xfer)
                begin
                    status_next = ST_OK;
                    pop_ok_next = 1'b0;
                    state_next  = S_DONE;
                    case (cmd_ch.cmd)
                        CMD_PUSH:
                        begin
                            if (full)
                            begin
                                status_next = ST_OVERFLOW;
                            end
                            else
                            begin
                                ram_req.we    = 1'b1;
                                ram_req.waddr = fill_reg[ADDR_W-1:0];
                                ram_req.wdata = cmd_ch.push_value;
                                fill_next     = au_res[CNT_W-1:0];
                            end
                        end
                        CMD_POP:
                        begin
                            if (fill_reg == '0)
                            begin
                                status_next = ST_UNDERFLOW;
                            end
                            else
                            begin
                                ram_req.re    = 1'b1;
                                ram_req.raddr = au_res[ADDR_W-1:0];
                                fill_next     = au_res[CNT_W-1:0];
                                pop_ok_next   = 1'b1;
                            end
                        end
                        CMD_REV:
                        begin
                            // Two or more entries: start swapping from both ends
                            if (fill_reg > CNT_W'(1))
                            begin
                                ram_req.re    = 1'b1;
                                ram_req.raddr = '0;
                                lo_next       = '0;
                                hi_next       = au_res[ADDR_W-1:0];
                                state_next    = S_RD_HI;
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_RD_LO:
            begin
                ram_req.re    = 1'b1;
                ram_req.raddr = lo_reg;
                state_next    = S_RD_HI;
            end
            S_RD_HI:
            begin
                // Low entry arrives; read the high one
                ram_req.re    = 1'b1;
                ram_req.raddr = hi_reg;
                tmp_next      = rdata;
                state_next    = S_WR_LO;
            end
            S_WR_LO:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = lo_reg;
                ram_req.wdata = rdata;
                state_next    = S_WR_HI;
            end
            S_WR_HI:
            begin
                // Finish the swap; another pair remains while hi - lo > 2
                ram_req.we    = 1'b1;
                ram_req.waddr = hi_reg;
                ram_req.wdata = tmp_reg;
                au_req.a      = CNT_W'(hi_reg);
                au_req.b      = CNT_W'(lo_reg);
                au_req.sub    = 1'b1;
                lo_next       = lo_reg + ADDR_W'(1);
                hi_next       = hi_reg - ADDR_W'(1);
                if (au_res > (CNT_W + 1)'(2))
                begin
                    state_next = S_RD_LO;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (load_res)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result register
    always_comb
    begin
        res_valid_next  = res_valid_reg;
        res_status_next = res_status_reg;
        res_pop_next    = res_pop_reg;
        res_count_next  = res_count_reg;
        if (load_res)
        begin
            res_valid_next  = 1'b1;
            res_status_next = status_reg;
            res_pop_next    = pop_ok_reg ? rdata : '0;
            res_count_next  = to_count(fill_reg);
        end
        else if (res_ch.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload and loop registers
    always_ff @(posedge clk)
    begin
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        tmp_reg        <= tmp_next;
        status_reg     <= status_next;
        pop_ok_reg     <= pop_ok_next;
        res_status_reg <= res_status_next;
        res_pop_reg    <= res_pop_next;
        res_count_reg  <= res_count_next;
    end

    assign res_ch.valid       = res_valid_reg;
    assign res_ch.status      = res_status_reg;
    assign res_ch.pop_value   = res_pop_reg;
    assign res_ch.entry_count = res_count_reg;

endmodule

FILE: sv/bsr_checker.sv
// Port-level checker for the bounded stack, bound to the top level below.
// Depends on bsr_pkg and bounded_stack_with_reverse_macros.svh.
`include "bounded_stack_with_reverse_macros.svh"

module bsr_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          cmd_valid,
    input logic                          cmd_ready,
    input logic                          res_valid,
    input logic                          res_ready,
    input logic [bsr_pkg::STAT_W-1:0]    status,
    input logic [bsr_pkg::DATA_W-1:0]    pop_value,
    input logic [bsr_pkg::COUNT_W-1:0]   entry_count
);
    import bsr_pkg::*;

    // A stalled result holds
    `BSR_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(status) && $stable(pop_value) && $stable(entry_count), "stalled result changed")

    // One command at a time: no transfer right after a transfer
    `BSR_ASSERT_NEXT(a_one_cmd, cmd_valid && cmd_ready, !cmd_ready, "command taken while busy")

    // A failed result carries no popped word
    `BSR_ASSERT_SAME(a_pop_zero, res_valid && status != ST_OK, pop_value == '0, "pop_value set on error")

    // Underflow only happens on an empty stack
    `BSR_ASSERT_SAME(a_under_empty, res_valid && status == ST_UNDERFLOW, entry_count == '0, "underflow with entries held")

endmodule

bind bounded_stack_with_reverse bsr_checker u_bsr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd_ch.valid),
    .cmd_ready   (cmd_ch.ready),
    .res_valid   (res_ch.valid),
    .res_ready   (res_ch.ready),
    .status      (res_ch.status),
    .pop_value   (res_ch.pop_value),
    .entry_count (res_ch.entry_count)
);
